// File: hw/rtl/polygon_normal_shade_macros.svh
// Assertion macros for the polygon normal block
`ifndef POLYGON_NORMAL_SHADE_MACROS_SVH
`define POLYGON_NORMAL_SHADE_MACROS_SVH
// Implication checked every clock, off in reset
`define PNS_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication
`define PNS_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/pns_pkg.sv
// Shared types and constants for the polygon normal block
package pns_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned SumW  = 40;
  localparam int unsigned NormW = 16;
  localparam int unsigned MagW  = 31;
  localparam int unsigned SqW   = 64;
  localparam int unsigned RootW = 32;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] vertex_z;
    logic               last_vertex;
  } vtx_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         shade_red;
    logic [7:0]         shade_green;
    logic [7:0]         shade_blue;
    logic               degenerate;
  } res_t;

  typedef struct packed {
    logic signed [SumW-1:0] sx;
    logic signed [SumW-1:0] sy;
    logic signed [SumW-1:0] sz;
  } sums_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NORM = 6'b000010,
    S_SQ   = 6'b000100,
    S_ROOT = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } back_state_e;

  function automatic logic [7:0] shade_of(logic signed [NormW-1:0] q);
    logic signed [31:0] t;
    t = 32'(signed'(q)) + 32'sd16384;
    t = t * 32'sd255 + 32'sd16384;
    return t[22:15];
  endfunction

endpackage

// File: hw/rtl/pns_front.sv
// Front part: takes vertices and accumulates the Newell sums
module pns_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  pns_pkg::vtx_t   vtx_i,
  input  logic            q_full_i,
  output logic            busy_o,
  output logic            push_o,
  output pns_pkg::sums_t  sums_o
);
  localparam int unsigned COORD_WIDTH = pns_pkg::CoordW;
  localparam int unsigned SW = pns_pkg::SumW;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  typedef enum logic [2:0] {
    F_TAKE  = 3'b001,
    F_ACC   = 3'b010,
    F_CLOSE = 3'b100
  } front_state_e;

  front_state_e st_q, st_d;
  logic inside_q;
  logic signed [COORD_WIDTH-1:0] fx_q, fy_q, fz_q, px_q, py_q, pz_q, cx_q, cy_q, cz_q;
  logic last_q;
  logic signed [SW-1:0] sx_q, sy_q, sz_q;

  logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz;
  logic signed [PW-1:0] tx, ty, tz;
  logic signed [SW+1:0] nx, ny, nz;
  logic signed [COORD_WIDTH-1:0] vx, vy, vz;

  function automatic logic signed [SW-1:0] sat(logic signed [SW+1:0] v);
    logic signed [SW+1:0] hi, lo;
    hi = (SW+2)'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - (SW+2)'(1);
    if (v > hi) return SW'(hi);
    if (v < lo) return SW'(lo);
    return SW'(v);
  endfunction

  assign vx = vtx_i.vertex_x[COORD_WIDTH-1:0];
  assign vy = vtx_i.vertex_y[COORD_WIDTH-1:0];
  assign vz = vtx_i.vertex_z[COORD_WIDTH-1:0];

  assign busy_o = (st_q != F_TAKE);

  // term of p with predecessor q
  always_comb begin
    if (st_q == F_CLOSE) begin
      ax = fx_q; ay = fy_q; az = fz_q; bx = cx_q; by = cy_q; bz = cz_q;
    end else begin
      ax = cx_q; ay = cy_q; az = cz_q; bx = px_q; by = py_q; bz = pz_q;
    end
    tx = PW'(ay * bz) - PW'(az * by);
    ty = PW'(az * bx) - PW'(ax * bz);
    tz = PW'(ax * by) - PW'(ay * bx);
    nx = (SW+2)'(sx_q) + (SW+2)'(tx);
    ny = (SW+2)'(sy_q) + (SW+2)'(ty);
    nz = (SW+2)'(sz_q) + (SW+2)'(tz);
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      F_TAKE:  if (start_i) st_d = F_ACC;
      F_ACC:   st_d = last_q ? F_CLOSE : F_TAKE;
      F_CLOSE: if (!q_full_i) st_d = F_TAKE;
      default: st_d = F_TAKE;
    endcase
  end

  assign push_o = (st_q == F_CLOSE) && !q_full_i;
  assign sums_o = '{sx: sat(nx), sy: sat(ny), sz: sat(nz)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_TAKE;
      inside_q <= 1'b0;
      sx_q <= '0; sy_q <= '0; sz_q <= '0;
    end else begin
      st_q <= st_d;
      case (st_q)
        F_TAKE: if (start_i && !inside_q) begin
          inside_q <= 1'b1;
          sx_q <= '0; sy_q <= '0; sz_q <= '0;
        end
        F_ACC: begin
          sx_q <= sat(nx); sy_q <= sat(ny); sz_q <= sat(nz);
        end
        F_CLOSE: if (!q_full_i) inside_q <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == F_TAKE && start_i) begin
      cx_q <= vx; cy_q <= vy; cz_q <= vz;
      last_q <= vtx_i.last_vertex;
      if (!inside_q) begin
        fx_q <= vx; fy_q <= vy; fz_q <= vz;
        px_q <= vx; py_q <= vy; pz_q <= vz;
      end
    end else if (st_q == F_ACC) begin
      px_q <= cx_q; py_q <= cy_q; pz_q <= cz_q;
    end
  end
endmodule

// File: hw/rtl/pns_queue.sv
// Two-entry queue of polygon sums between front and back
module pns_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pns_pkg::sums_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output pns_pkg::sums_t data_o
);
  `include "polygon_normal_shade_macros.svh"

  pns_pkg::sums_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  `PNS_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `PNS_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)
  `PNS_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
endmodule

// File: hw/rtl/pns_back.sv
// Back part: normalises sums by an iterative root and divide, emits the result
module pns_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  pns_pkg::sums_t sums_i,
  output logic           pop_o,
  output logic           valid_o,
  output pns_pkg::res_t  res_o
);
  `include "polygon_normal_shade_macros.svh"
  localparam int unsigned SW = pns_pkg::SumW;
  localparam int unsigned MW = pns_pkg::MagW;
  localparam int unsigned QW = pns_pkg::SqW;
  localparam int unsigned RW = pns_pkg::RootW;
  localparam int unsigned DW = MW + 15;
  localparam int unsigned NormWLoc = pns_pkg::NormW;

  pns_pkg::back_state_e st_q, st_d;
  logic [2:0] sgn_q;
  logic [SW-1:0] m0_q, m1_q, m2_q;
  logic [MW-1:0] a_q [3];
  logic [QW-1:0] sq_q, rem_q;
  logic [RW-1:0] root_q;
  logic [5:0] cnt_q;
  logic [1:0] ci_q;
  logic [DW-1:0] num_q;
  logic [DW-1:0] quo_q;
  logic [DW:0] drem_q;
  logic signed [NormWLoc-1:0] n_q [3];
  logic deg_q;

  logic [SW-1:0] mx;
  logic [5:0] len;
  logic [QW+1:0] rtry;
  logic [QW-1:0] rnew;
  logic [DW:0] dsub;
  logic [NormWLoc-1:0] cq;

  always_comb begin
    mx = m0_q;
    if (m1_q > mx) mx = m1_q;
    if (m2_q > mx) mx = m2_q;
    len = '0;
    for (int i = 0; i < SW; i++) if (mx[i]) len = 6'(i + 1);
  end

  // one root bit per step, from the top
  always_comb begin
    rnew = {rem_q[QW-3:0], sq_q[QW-1:QW-2]};
    rtry = (QW+2)'(rnew) - (QW+2)'({root_q, 2'b01});
  end

  assign dsub = {drem_q[DW-1:0], num_q[DW-1]} - (DW+1)'(root_q);
  assign cq = (quo_q > DW'(16384)) ? NormWLoc'(16384) : NormWLoc'(quo_q);

  always_comb begin
    st_d = st_q;
    case (st_q)
      pns_pkg::S_IDLE: if (!empty_i) st_d = pns_pkg::S_NORM;
      pns_pkg::S_NORM: st_d = (len == '0) ? pns_pkg::S_OUT : pns_pkg::S_SQ;
      pns_pkg::S_SQ:   if (ci_q == 2'd2) st_d = pns_pkg::S_ROOT;
      pns_pkg::S_ROOT: if (cnt_q == 6'd31) st_d = pns_pkg::S_DIV;
      pns_pkg::S_DIV:  if (cnt_q == 6'(DW + 1) && ci_q == 2'd2) st_d = pns_pkg::S_OUT;
      pns_pkg::S_OUT:  st_d = pns_pkg::S_IDLE;
      default:         st_d = pns_pkg::S_IDLE;
    endcase
  end

  assign pop_o   = (st_q == pns_pkg::S_IDLE) && !empty_i;
  assign valid_o = (st_q == pns_pkg::S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= pns_pkg::S_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      pns_pkg::S_IDLE: begin
        sgn_q <= {sums_i.sz[SW-1], sums_i.sy[SW-1], sums_i.sx[SW-1]};
        m0_q <= sums_i.sx[SW-1] ? SW'(-sums_i.sx) : SW'(sums_i.sx);
        m1_q <= sums_i.sy[SW-1] ? SW'(-sums_i.sy) : SW'(sums_i.sy);
        m2_q <= sums_i.sz[SW-1] ? SW'(-sums_i.sz) : SW'(sums_i.sz);
        sq_q <= '0; ci_q <= '0;
      end
      pns_pkg::S_NORM: begin
        deg_q <= (len == '0);
        for (int i = 0; i < 3; i++) begin
          n_q[i] <= '0;
        end
        if (len > 6'd30) begin
          a_q[0] <= MW'(m0_q >> (len - 6'd30));
          a_q[1] <= MW'(m1_q >> (len - 6'd30));
          a_q[2] <= MW'(m2_q >> (len - 6'd30));
        end else begin
          a_q[0] <= MW'(m0_q << (6'd30 - len));
          a_q[1] <= MW'(m1_q << (6'd30 - len));
          a_q[2] <= MW'(m2_q << (6'd30 - len));
        end
      end
      pns_pkg::S_SQ: begin
        sq_q <= sq_q + QW'(a_q[ci_q] * a_q[ci_q]);
        ci_q <= (ci_q == 2'd2) ? 2'd0 : ci_q + 2'd1;
        rem_q <= '0; root_q <= '0; cnt_q <= '0;
      end
      pns_pkg::S_ROOT: begin
        sq_q <= {sq_q[QW-3:0], 2'b00};
        if (!rtry[QW+1]) begin
          rem_q <= QW'(rtry); root_q <= {root_q[RW-2:0], 1'b1};
        end else begin
          rem_q <= rnew; root_q <= {root_q[RW-2:0], 1'b0};
        end
        cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          ci_q <= '0;
        end
      end
      pns_pkg::S_DIV: begin
        if (cnt_q == 6'd0) begin
          num_q <= (DW'(a_q[ci_q]) << 14) + DW'(root_q >> 1);
          drem_q <= '0; quo_q <= '0;
          cnt_q <= 6'd1;
        end else if (cnt_q <= 6'(DW)) begin
          num_q <= {num_q[DW-2:0], 1'b0};
          if (!dsub[DW]) begin
            drem_q <= dsub; quo_q <= {quo_q[DW-2:0], 1'b1};
          end else begin
            drem_q <= {drem_q[DW-1:0], num_q[DW-1]}; quo_q <= {quo_q[DW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
        end else begin
          n_q[ci_q] <= sgn_q[ci_q] ? -signed'(cq) : signed'(cq);
          ci_q <= ci_q + 2'd1;
          cnt_q <= 6'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.normal_x    = n_q[0];
    res_o.normal_y    = n_q[1];
    res_o.normal_z    = n_q[2];
    res_o.shade_red   = pns_pkg::shade_of(n_q[0]);
    res_o.shade_green = pns_pkg::shade_of(n_q[1]);
    res_o.shade_blue  = pns_pkg::shade_of(n_q[2]);
    res_o.degenerate  = deg_q;
  end

  `PNS_ASSERT_NXT(a_out_one, clk_i, rst_ni, valid_o, !valid_o)
  `PNS_ASSERT_NXT(a_pop_norm, clk_i, rst_ni, pop_o, st_q == pns_pkg::S_NORM)
  `PNS_ASSERT_IMP(a_deg_zero, clk_i, rst_ni, valid_o && res_o.degenerate,
                  res_o.normal_x == '0)
endmodule

// File: hw/rtl/polygon_normal_shade.sv
// Polygon normal and shade: top level
// Each vertex passes a take and an accumulate state, so busy is high for one cycle
// after every accepted beat but a polygon's last; the last vertex adds a closing state
// for the closing term, held longer while the two-deep sum queue is full. The back
// end finds a 64-bit integer square root one bit a cycle and three 46-bit restoring
// divides one bit a cycle, overlapped with the next polygon's vertices. The result
// strobe result_valid_o is high for one cycle per polygon and cannot be held off.
module polygon_normal_shade (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pns_pkg::vtx_t vertex_i,
  output logic          result_valid_o,
  output pns_pkg::res_t result_o
);
  logic push, full, pop, empty;
  pns_pkg::sums_t sums_in, sums_out;

  pns_front u_front (
    .clk_i, .rst_ni, .start_i(start), .vtx_i(vertex_i), .q_full_i(full),
    .busy_o(busy), .push_o(push), .sums_o(sums_in)
  );

  pns_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(sums_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .data_o(sums_out)
  );

  pns_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .sums_i(sums_out), .pop_o(pop),
    .valid_o(result_valid_o), .res_o(result_o)
  );
endmodule

// File: tb/tb_top.sv
// Testbench for polygon_normal_shade: directed table plus random polygons, self-checking
module tb_top;

  localparam int unsigned WDOG_LIMIT = 4000;
  localparam int unsigned PHASE_BEATS = 110;

  typedef struct {
    pns_pkg::vtx_t v;
    bit            fixed;
    pns_pkg::res_t r;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  pns_pkg::vtx_t vertex_i;
  logic result_valid_o;
  pns_pkg::res_t result_o;

  polygon_normal_shade dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .vertex_i,
    .result_valid_o,
    .result_o
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // predictor state
  logic signed [15:0] first_v [3];
  logic signed [15:0] prev_v  [3];
  longint             newell_sum [3];
  bit                 in_poly;

  pns_pkg::res_t normals_due [$];
  dir_row_t      dir_tab [$];
  int            errors;
  int            idle_pct;
  int unsigned   quiet_cycles;

  function automatic longint sat40(longint v);
    longint hi;
    hi = (longint'(1) <<< 39) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic void add_newell(longint px, longint py, longint pz,
                                     longint qx, longint qy, longint qz);
    newell_sum[0] = sat40(newell_sum[0] + (py * qz - pz * qy));
    newell_sum[1] = sat40(newell_sum[1] + (pz * qx - px * qz));
    newell_sum[2] = sat40(newell_sum[2] + (px * qy - py * qx));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] shade_calc(longint q);
    longint t;
    t = (255 * (q + 16384) + 16384) >>> 15;
    return t[7:0];
  endfunction

  // takes one vertex; returns 1 with the expected normal when the polygon closes
  function automatic bit predict_normal(pns_pkg::vtx_t v, output pns_pkg::res_t r);
    longint unsigned a [3];
    longint unsigned m, sq, c;
    longint q [3];
    int len;
    if (!in_poly) begin
      first_v = '{v.vertex_x, v.vertex_y, v.vertex_z};
      prev_v = first_v;
      newell_sum = '{0, 0, 0};
      in_poly = 1'b1;
    end
    add_newell(v.vertex_x, v.vertex_y, v.vertex_z, prev_v[0], prev_v[1], prev_v[2]);
    prev_v = '{v.vertex_x, v.vertex_y, v.vertex_z};
    if (!v.last_vertex) return 1'b0;
    add_newell(first_v[0], first_v[1], first_v[2], v.vertex_x, v.vertex_y, v.vertex_z);
    in_poly = 1'b0;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = newell_sum[i] < 0 ? -newell_sum[i] : newell_sum[i];
      if (a[i] > m) m = a[i];
    end
    q = '{0, 0, 0};
    if (m != 0) begin
      len = 0;
      while ((m >> len) != 0) len++;
      for (int i = 0; i < 3; i++)
        a[i] = (len > 30) ? (a[i] >> (len - 30)) : (a[i] << (30 - len));
      sq = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      for (int i = 0; i < 3; i++) begin
        c = (64'd16384 * a[i] + (sq >> 1)) / sq;
        if (c > 16384) c = 16384;
        q[i] = newell_sum[i] < 0 ? -longint'(c) : longint'(c);
      end
    end
    r.normal_x = q[0][15:0];
    r.normal_y = q[1][15:0];
    r.normal_z = q[2][15:0];
    r.shade_red = shade_calc(q[0]);
    r.shade_green = shade_calc(q[1]);
    r.shade_blue = shade_calc(q[2]);
    r.degenerate = (m == 0);
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(int x, int y, int z, bit lst, bit fx = 0,
                                      int nx = 0, int ny = 0, int nz = 0,
                                      int cr = 0, int cg = 0, int cb = 0, bit dg = 0);
    dir_row_t d;
    d.v = '{vertex_x: x[15:0], vertex_y: y[15:0], vertex_z: z[15:0], last_vertex: lst};
    d.fixed = fx;
    d.r = '{normal_x: nx[15:0], normal_y: ny[15:0], normal_z: nz[15:0],
            shade_red: cr[7:0], shade_green: cg[7:0], shade_blue: cb[7:0], degenerate: dg};
    return d;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sd0;
      default: return 16'($urandom());
    endcase
  endfunction

  // one beat: hold start until accepted, then predict
  task automatic send_vertex(pns_pkg::vtx_t v, bit fixed = 0, pns_pkg::res_t fixed_r = '0);
    pns_pkg::res_t pr;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start <= 1'b1;
    vertex_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (predict_normal(v, pr)) normals_due.push_back(fixed ? fixed_r : pr);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (normals_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", result_o);
      end else begin
        pns_pkg::res_t e;
        e = normals_due.pop_front();
        if (result_o !== e) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", e, result_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    pns_pkg::vtx_t v;
    int n, beats;
    rst_ni = 1'b0;
    start = 1'b0;
    vertex_i = '0;
    errors = 0;
    idle_pct = 0;
    in_poly = 1'b0;
    newell_sum = '{0, 0, 0};
    quiet_cycles = 0;

    // single vertices, flat triangles both windings, collinear, extreme quad
    dir_tab.push_back(mk_row(0, 0, 0, 1, 1, 0, 0, 0, 128, 128, 128, 1));
    dir_tab.push_back(mk_row(32767, -32768, 32767, 1, 1, 0, 0, 0, 128, 128, 128, 1));
    dir_tab.push_back(mk_row(0, 0, 0, 0));
    dir_tab.push_back(mk_row(4096, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 4096, 0, 1, 1, 0, 0, -16384, 128, 128, 0, 0));
    dir_tab.push_back(mk_row(0, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 4096, 0, 0));
    dir_tab.push_back(mk_row(4096, 0, 0, 1, 1, 0, 0, 16384, 128, 128, 255, 0));
    dir_tab.push_back(mk_row(1, 1, 1, 0));
    dir_tab.push_back(mk_row(2, 2, 2, 0));
    dir_tab.push_back(mk_row(3, 3, 3, 1, 1, 0, 0, 0, 128, 128, 128, 1));
    dir_tab.push_back(mk_row(0, 0, 0, 0));
    dir_tab.push_back(mk_row(0, 1, 0, 0));
    dir_tab.push_back(mk_row(0, 0, 1, 1));
    dir_tab.push_back(mk_row(-32768, -32768, 0, 0));
    dir_tab.push_back(mk_row(32767, -32768, -32768, 0));
    dir_tab.push_back(mk_row(32767, 32767, 0, 0));
    dir_tab.push_back(mk_row(-32768, 32767, 32767, 1));
    dir_tab.push_back(mk_row(-32768, 32767, -32768, 0));
    dir_tab.push_back(mk_row(32767, -32768, 32767, 1));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_vertex(dir_tab[i].v, dir_tab[i].fixed, dir_tab[i].r);

    // extreme square wound many times drives the z sum into saturation
    for (int i = 0; i < 300; i++) begin
      v = '0;
      case (i % 4)
        0: begin v.vertex_x = 16'sh7fff; v.vertex_y = 16'sh7fff; end
        1: begin v.vertex_x = 16'sh8000; v.vertex_y = 16'sh7fff; end
        2: begin v.vertex_x = 16'sh8000; v.vertex_y = 16'sh8000; end
        default: begin v.vertex_x = 16'sh7fff; v.vertex_y = 16'sh8000; end
      endcase
      v.last_vertex = (i == 299);
      send_vertex(v);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 32 : (ph == 1) ? 76 : 0;
      beats = 0;
      while (beats < PHASE_BEATS) begin
        case ($urandom_range(9))
          0: n = $urandom_range(1, 2);
          1: n = $urandom_range(9, 64);
          default: n = $urandom_range(3, 8);
        endcase
        for (int k = 0; k < n; k++) begin
          v.vertex_x = rand_coord();
          v.vertex_y = rand_coord();
          v.vertex_z = rand_coord();
          v.last_vertex = (k == n - 1);
          send_vertex(v);
        end
        beats += n;
      end
    end
    start <= 1'b0;

    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: polygon_normal_shade.f
+incdir+hw/rtl
hw/rtl/pns_pkg.sv
hw/rtl/pns_front.sv
hw/rtl/pns_queue.sv
hw/rtl/pns_back.sv
hw/rtl/polygon_normal_shade.sv
tb/tb_top.sv
